[rtl/krsc_pkg.sv]
// ---------------------------------------------------------------------------
// krsc_pkg
// Shared constants, codes and control types of the keyed report slot cache.
// ---------------------------------------------------------------------------
package krsc_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int SLOT_BYTES = 64;

  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int BYTE_W    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int MEM_DEPTH = NUM_SLOTS * SLOT_BYTES;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Field widths fixed by the interface
  localparam int OP_W  = 2;
  localparam int ID_W  = 8;
  localparam int DAT_W = 8;
  localparam int CAP_W = 16;
  localparam int CNT_W = 7;

  localparam logic [OP_W-1:0] OP_STORE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [CNT_W-1:0] SLOT_BYTES_C = CNT_W'(SLOT_BYTES);

  typedef struct packed {
    logic latch;      // capture input beat
    logic lookup;     // register tag hit and free vectors
    logic select;     // encode hit / free slot
    logic open;       // open a store burst on the selected slot
    logic store;      // write one byte, commit on last
    logic clear;      // free all slots
    logic rd_len;     // compute read byte count
    logic rd_addr;    // issue payload memory read
    logic emit;       // load output register
    logic emit_data;  // emitted result carries a payload byte
  } krsc_cmd_t;

  typedef struct packed {
    logic burst_active;
    logic is_read;
    logic last;
    logic rd_bytes;
    logic rd_last;
    logic out_free;
  } krsc_sts_t;

  // Lowest set bit of a slot vector
  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/krsc_ctrl.sv]
// ---------------------------------------------------------------------------
// krsc_ctrl
// Sequencer of the slot cache: steps each input beat through lookup,
// store, clear and read phases and paces results against the output side.
// ---------------------------------------------------------------------------
module krsc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [krsc_pkg::OP_W-1:0] in_op,
  output logic                     in_stall,
  input  krsc_pkg::krsc_sts_t      sts,
  output krsc_pkg::krsc_cmd_t      cmd
);
  import krsc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_LOOKUP  = 9'b000000010,
    ST_SELECT  = 9'b000000100,
    ST_STORE   = 9'b000001000,
    ST_CLEAR   = 9'b000010000,
    ST_RD_LEN  = 9'b000100000,
    ST_RD_ADDR = 9'b001000000,
    ST_RD_DATA = 9'b010000000,
    ST_EMIT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_op)
            OP_STORE: state_nxt = sts.burst_active ? ST_STORE : ST_LOOKUP;
            OP_READ:  state_nxt = ST_LOOKUP;
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_NOP:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_SELECT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        cmd.open   = !sts.is_read;
        state_nxt  = sts.is_read ? ST_RD_LEN : ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_RD_LEN: begin
        cmd.rd_len = 1'b1;
        state_nxt  = sts.rd_bytes ? ST_RD_ADDR : ST_EMIT;
      end
      ST_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_data = 1'b1;
          state_nxt     = sts.rd_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/krsc_dp.sv]
// ---------------------------------------------------------------------------
// krsc_dp
// Datapath of the slot cache: tag table, used marks, lengths, payload
// memory, burst tracking and the result output register.
// ---------------------------------------------------------------------------
module krsc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  krsc_pkg::krsc_cmd_t         cmd,
  output krsc_pkg::krsc_sts_t         sts,
  input  logic [krsc_pkg::OP_W-1:0]   in_op,
  input  logic [krsc_pkg::ID_W-1:0]   in_report_id,
  input  logic [krsc_pkg::DAT_W-1:0]  in_data_byte,
  input  logic                        in_byte_valid,
  input  logic                        in_last,
  input  logic [krsc_pkg::CAP_W-1:0]  in_capacity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic                        out_ok,
  output logic [krsc_pkg::DAT_W-1:0]  out_read_byte,
  output logic [krsc_pkg::CNT_W-1:0]  out_byte_count,
  output logic                        out_end_of_run
);
  import krsc_pkg::*;

  // Captured input beat
  logic [OP_W-1:0]  op_r;
  logic [ID_W-1:0]  id_r;
  logic [DAT_W-1:0] data_r;
  logic             bv_r;
  logic             last_r;
  logic [CAP_W-1:0] cap_r;

  // Slot table
  logic [NUM_SLOTS-1:0] used_r;
  logic [ID_W-1:0]      tag_r [NUM_SLOTS];
  logic [CNT_W-1:0]     len_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] hit_r;
  logic [NUM_SLOTS-1:0] free_r;
  logic                 found_r;
  logic [SLOT_W-1:0]    slot_r;

  // Open burst
  logic              burst_active_r;
  logic              burst_dropped_r;
  logic [CNT_W-1:0]  burst_cnt_r;
  logic [SLOT_W-1:0] burst_slot_r;

  // Pending result fields and read cursor
  logic             res_ok_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic [CNT_W-1:0] rd_k_r;

  logic [DAT_W-1:0] mem [MEM_DEPTH];
  logic [DAT_W-1:0] mem_rdata_r;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic             out_ok_r;
  logic [DAT_W-1:0] out_byte_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_eor_r;

  logic              hit_any, free_any;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic              store_wr;
  logic [CNT_W-1:0]  cnt_inc;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]  len_sel, rd_n;
  logic              rd_last;
  logic [1:0]        kind_sel;

  assign hit_any  = |hit_r;
  assign free_any = |free_r;
  assign hit_idx  = first_set(hit_r);
  assign free_idx = first_set(free_r);

  assign store_wr = bv_r && !burst_dropped_r && (burst_cnt_r < SLOT_BYTES_C);
  assign cnt_inc  = burst_cnt_r + CNT_W'(store_wr);

  assign wr_addr = ADDR_W'(32'(burst_slot_r) * SLOT_BYTES + 32'(burst_cnt_r[BYTE_W-1:0]));
  assign rd_addr = ADDR_W'(32'(slot_r) * SLOT_BYTES + 32'(rd_k_r[BYTE_W-1:0]));

  assign len_sel = len_r[slot_r];
  assign rd_n    = (cap_r < CAP_W'(len_sel)) ? cap_r[CNT_W-1:0] : len_sel;
  assign rd_last = ((rd_k_r + CNT_W'(1)) == res_cnt_r);

  always_comb begin
    unique case (op_r)
      OP_STORE: kind_sel = KIND_STORE;
      OP_READ:  kind_sel = KIND_READ;
      OP_CLEAR: kind_sel = KIND_CLEAR;
      default:  kind_sel = KIND_STORE;
    endcase
  end

  assign sts.burst_active = burst_active_r;
  assign sts.is_read      = (op_r == OP_READ);
  assign sts.last         = last_r;
  assign sts.rd_bytes     = found_r && (rd_n != '0);
  assign sts.rd_last      = rd_last;
  assign sts.out_free     = !out_valid_r || !out_stall;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      id_r   <= in_report_id;
      data_r <= in_data_byte;
      bv_r   <= in_byte_valid;
      last_r <= in_last;
      cap_r  <= in_capacity;
    end
    if (cmd.lookup) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        hit_r[i]  <= used_r[i] && (tag_r[i] == id_r);
        free_r[i] <= !used_r[i];
      end
    end
    if (cmd.select) begin
      found_r <= hit_any;
      slot_r  <= hit_idx;
    end
    if (cmd.open && (hit_any || free_any)) begin
      tag_r[hit_any ? hit_idx : free_idx] <= id_r;
    end
    if (cmd.store && last_r && !burst_dropped_r) begin
      len_r[burst_slot_r] <= cnt_inc;
    end
    if (cmd.open) begin
      burst_slot_r <= (hit_any || free_any) ? (hit_any ? hit_idx : free_idx) : '0;
    end
    if (cmd.store) begin
      res_ok_r  <= !burst_dropped_r;
      res_cnt_r <= burst_dropped_r ? '0 : cnt_inc;
    end else if (cmd.clear) begin
      res_ok_r  <= 1'b1;
      res_cnt_r <= '0;
    end else if (cmd.rd_len) begin
      res_ok_r  <= found_r;
      res_cnt_r <= found_r ? rd_n : '0;
    end
    if (cmd.rd_len) begin
      rd_k_r <= '0;
    end else if (cmd.emit && cmd.emit_data) begin
      rd_k_r <= rd_k_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      out_kind_r <= kind_sel;
      out_ok_r   <= res_ok_r;
      out_byte_r <= cmd.emit_data ? mem_rdata_r : '0;
      out_cnt_r  <= res_cnt_r;
      out_eor_r  <= cmd.emit_data ? rd_last : 1'b1;
    end
  end

  // Payload memory
  always_ff @(posedge clk) begin
    if (cmd.store && store_wr) begin
      mem[wr_addr] <= data_r;
    end
    if (cmd.rd_addr) begin
      mem_rdata_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r          <= '0;
      burst_active_r  <= 1'b0;
      burst_dropped_r <= 1'b0;
      burst_cnt_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        used_r          <= '0;
        burst_active_r  <= 1'b0;
        burst_dropped_r <= 1'b0;
        burst_cnt_r     <= '0;
      end else if (cmd.open) begin
        burst_active_r  <= 1'b1;
        burst_dropped_r <= !(hit_any || free_any);
        burst_cnt_r     <= '0;
      end else if (cmd.store) begin
        if (last_r) begin
          if (!burst_dropped_r) used_r[burst_slot_r] <= 1'b1;
          burst_active_r  <= 1'b0;
          burst_dropped_r <= 1'b0;
          burst_cnt_r     <= '0;
        end else begin
          burst_cnt_r <= cnt_inc;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_ok         = out_ok_r;
  assign out_read_byte  = out_byte_r;
  assign out_byte_count = out_cnt_r;
  assign out_end_of_run = out_eor_r;

endmodule

[rtl/keyed_report_slot_cache.sv]
// ---------------------------------------------------------------------------
// keyed_report_slot_cache
// Fully associative table of tagged report slots with byte payload storage.
// ---------------------------------------------------------------------------
// Input channel (in_*): one beat per store byte, read or clear request.
// A store burst's first beat picks the slot holding its id or the lowest
// free slot (full table: burst dropped); its last beat commits the slot and
// gives one status result. A read gives one result per copied byte, or a
// single not-found / empty result. A clear frees all slots, one result.
// Result channel (out_*): registered; out_end_of_run marks the last result
// of an input beat.
// Steps per beat: a store beat inside an open burst goes straight to the
// write; the burst's first beat is preceded by tag compare and slot encode
// (registered steps), and the last beat adds the status result. A read
// finds the slot and length, then reads and emits each byte in turn, bound
// by the single registered port of the payload memory.
// One beat is worked on at a time; in_stall is high until it is done.
// If out_stall holds, the block waits with the result in the output
// register. After reset all slots are free and no burst is open.
// ---------------------------------------------------------------------------
module keyed_report_slot_cache (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [krsc_pkg::OP_W-1:0]   in_op,
  input  logic [krsc_pkg::ID_W-1:0]   in_report_id,
  input  logic [krsc_pkg::DAT_W-1:0]  in_data_byte,
  input  logic                        in_byte_valid,
  input  logic                        in_last,
  input  logic [krsc_pkg::CAP_W-1:0]  in_capacity,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic                        out_ok,
  output logic [krsc_pkg::DAT_W-1:0]  out_read_byte,
  output logic [krsc_pkg::CNT_W-1:0]  out_byte_count,
  output logic                        out_end_of_run
);
  import krsc_pkg::*;

  krsc_cmd_t cmd;
  krsc_sts_t sts;

  krsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  krsc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_report_id   (in_report_id),
    .in_data_byte   (in_data_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .in_capacity    (in_capacity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_ok         (out_ok),
    .out_read_byte  (out_read_byte),
    .out_byte_count (out_byte_count),
    .out_end_of_run (out_end_of_run)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed report slot cache.
// A scripted opening part hits empty and full tables, truncated and empty
// bursts, contains queries, reads inside an open burst and clears. Random
// bursts, reads and clears then run under bursty input and a stalling
// result side. Every result beat is checked against the script's expected
// reply or against a behavioral copy of the slot table.
// ---------------------------------------------------------------------------
module tb;
  import krsc_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int SETTLE       = 40;
  localparam int WATCHDOG     = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int ID_POOL      = 48;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [DAT_W-1:0] data;
    logic             bv;
    logic             last;
    logic [CAP_W-1:0] cap;
  } beat_t;

  typedef struct {
    logic [1:0]       kind;
    logic             ok;
    logic [DAT_W-1:0] rbyte;
    logic [CNT_W-1:0] cnt;
    logic             eor;
  } reply_t;

  typedef struct {
    beat_t  b;
    int     reps;
    bit     typed;
    reply_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = OP_NOP;
  logic [ID_W-1:0]   in_report_id = '0;
  logic [DAT_W-1:0]  in_data_byte = '0;
  logic              in_byte_valid = 1'b0;
  logic              in_last = 1'b0;
  logic [CAP_W-1:0]  in_capacity = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  logic              out_ok;
  logic [DAT_W-1:0]  out_read_byte;
  logic [CNT_W-1:0]  out_byte_count;
  logic              out_end_of_run;

  keyed_report_slot_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_report_id   (in_report_id),
    .in_data_byte   (in_data_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .in_capacity    (in_capacity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_ok         (out_ok),
    .out_read_byte  (out_read_byte),
    .out_byte_count (out_byte_count),
    .out_end_of_run (out_end_of_run)
  );

  always #1 clk = ~clk;

  // Shadow copy of the slot table
  logic             slot_used [NUM_SLOTS];
  logic [ID_W-1:0]  slot_tag  [NUM_SLOTS];
  logic [CNT_W-1:0] slot_len  [NUM_SLOTS];
  logic [DAT_W-1:0] slot_data [NUM_SLOTS * SLOT_BYTES];
  logic             burst_open = 1'b0;
  logic             burst_drop = 1'b0;
  int               burst_slot = 0;
  int               burst_cnt = 0;

  reply_t beat_replies[$];
  reply_t replies_due[$];

  int errors = 0;
  int results_checked = 0;
  int items_sent = 0;
  int drops_seen = 0;
  int bytes_cut = 0;
  int misses_seen = 0;
  int idle_cycles = 0;

  // Driver-side tag for the beat on the input ports
  bit     cur_typed = 1'b0;
  reply_t cur_want;

  // Sender and receiver pacing
  int unsigned stall_pct = 0;
  int unsigned gap_max = 0;
  int          burst_left = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  int unsigned stall_plan[6] = '{0, 30, 70, 15, 0, 45};
  int unsigned gap_plan[6]   = '{0, 4, 2, 10, 0, 6};

  logic [ID_W-1:0] id_pool[ID_POOL];
  row_t            script[$];
  beat_t           taken;
  reply_t          due;

  function automatic reply_t reply(logic [1:0] kind, logic ok, logic [DAT_W-1:0] rbyte,
                                   logic [CNT_W-1:0] cnt, logic eor);
    reply_t r;
    r.kind = kind; r.ok = ok; r.rbyte = rbyte; r.cnt = cnt; r.eor = eor;
    return r;
  endfunction

  function automatic beat_t beat(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [DAT_W-1:0] data, logic bv, logic last,
                                 logic [CAP_W-1:0] cap);
    beat_t b;
    b.op = op; b.id = id; b.data = data; b.bv = bv; b.last = last; b.cap = cap;
    return b;
  endfunction

  function automatic row_t step_row(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                    logic [DAT_W-1:0] data, logic bv, logic last,
                                    logic [CAP_W-1:0] cap, int reps, bit typed,
                                    logic [1:0] kind, logic ok, logic [CNT_W-1:0] cnt);
    row_t r;
    r.b = beat(op, id, data, bv, last, cap);
    r.reps = reps;
    r.typed = typed;
    r.want = reply(kind, ok, '0, cnt, 1'b1);
    return r;
  endfunction

  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_used[i] && slot_tag[i] == id) return i;
    end
    return NUM_SLOTS;
  endfunction

  // Advances the shadow table by one input beat; its results land in beat_replies
  function automatic void derive_replies(beat_t b);
    int s;
    int n;
    beat_replies.delete();
    case (b.op)
      OP_STORE: begin
        if (!burst_open) begin
          s = find_slot(b.id);
          if (s == NUM_SLOTS) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (!slot_used[i]) begin
                s = i;
                break;
              end
            end
          end
          burst_open = 1'b1;
          burst_cnt = 0;
          if (s == NUM_SLOTS) begin
            burst_drop = 1'b1;
            burst_slot = 0;
          end else begin
            burst_drop = 1'b0;
            burst_slot = s;
            slot_tag[s] = b.id;
          end
        end
        if (b.bv && !burst_drop) begin
          if (burst_cnt < SLOT_BYTES) begin
            slot_data[burst_slot * SLOT_BYTES + burst_cnt] = b.data;
            burst_cnt++;
          end else begin
            bytes_cut++;
          end
        end
        if (b.last) begin
          burst_open = 1'b0;
          if (burst_drop) begin
            burst_drop = 1'b0;
            drops_seen++;
            beat_replies.push_back(reply(KIND_STORE, 1'b0, '0, '0, 1'b1));
          end else begin
            slot_used[burst_slot] = 1'b1;
            slot_len[burst_slot] = CNT_W'(burst_cnt);
            beat_replies.push_back(reply(KIND_STORE, 1'b1, '0, CNT_W'(burst_cnt), 1'b1));
          end
          burst_cnt = 0;
        end
      end
      OP_READ: begin
        s = find_slot(b.id);
        if (s == NUM_SLOTS) begin
          misses_seen++;
          beat_replies.push_back(reply(KIND_READ, 1'b0, '0, '0, 1'b1));
        end else begin
          n = int'(slot_len[s]);
          if (n > SLOT_BYTES) n = SLOT_BYTES;
          if (int'(b.cap) < n) n = int'(b.cap);
          if (n == 0) begin
            beat_replies.push_back(reply(KIND_READ, 1'b1, '0, '0, 1'b1));
          end else begin
            for (int k = 0; k < n; k++) begin
              beat_replies.push_back(reply(KIND_READ, 1'b1, slot_data[s * SLOT_BYTES + k],
                                           CNT_W'(n), k == n - 1));
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          slot_used[i] = 1'b0;
          slot_len[i] = '0;
        end
        burst_open = 1'b0;
        burst_drop = 1'b0;
        burst_cnt = 0;
        beat_replies.push_back(reply(KIND_CLEAR, 1'b1, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // Both channels are sampled here, at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      taken = beat(in_op, in_report_id, in_data_byte, in_byte_valid, in_last, in_capacity);
      derive_replies(taken);
      if (cur_typed) begin
        replies_due.push_back(cur_want);
      end else begin
        foreach (beat_replies[i]) replies_due.push_back(beat_replies[i]);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t ns: unexpected result: kind %0d ok %0d byte %02h count %0d end %0d",
                 $time, out_kind, out_ok, out_read_byte, out_byte_count, out_end_of_run);
        errors++;
      end else begin
        due = replies_due.pop_front();
        results_checked++;
        if (out_kind !== due.kind || out_ok !== due.ok || out_read_byte !== due.rbyte ||
            out_byte_count !== due.cnt || out_end_of_run !== due.eor) begin
          $display("%0t ns: mismatch: expected kind %0d ok %0d byte %02h count %0d end %0d",
                   $time, due.kind, due.ok, due.rbyte, due.cnt, due.eor);
          $display("%0t ns:           actual   kind %0d ok %0d byte %02h count %0d end %0d",
                   $time, out_kind, out_ok, out_read_byte, out_byte_count, out_end_of_run);
          errors++;
        end
      end
    end
  end

  // Receiver: long hold on request, otherwise a random stall pattern
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG) @(posedge clk);
    $display("%0t ns: no beat moved for %0d cycles, %0d results outstanding",
             $time, WATCHDOG, replies_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic offer(beat_t b, bit typed, reply_t want);
    @(negedge clk);
    in_valid = 1'b1;
    in_op = b.op;
    in_report_id = b.id;
    in_data_byte = b.data;
    in_byte_valid = b.bv;
    in_last = b.last;
    in_capacity = b.cap;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (in_stall);
    if (b.op != OP_NOP) items_sent++;
    // sender idles between bursts of beats
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max != 0) begin
        repeat ($urandom_range(0, gap_max)) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
    end
  endtask

  task automatic send(beat_t b);
    offer(b, 1'b0, reply('0, 1'b0, '0, '0, 1'b0));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
    return id_pool[$urandom_range(0, ID_POOL - 1)];
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CAP_W'($urandom_range(1, 8));
      2: return '1;
      default: return CAP_W'($urandom);
    endcase
  endfunction

  function automatic beat_t read_beat();
    return beat(OP_READ, pick_id(), DAT_W'($urandom), 1'($urandom), 1'($urandom), pick_cap());
  endfunction

  // Well-formed store burst, sometimes interleaved with reads or cut by a clear
  task automatic send_burst(logic [ID_W-1:0] id, int len);
    beat_t b;
    for (int k = 0; k < len; k++) begin
      b = beat(OP_STORE, (k == 0) ? id : ID_W'($urandom), DAT_W'($urandom),
               $urandom_range(0, 9) != 0, k == len - 1, CAP_W'($urandom));
      send(b);
      if (k != len - 1 && $urandom_range(0, 19) == 0) send(read_beat());
      if (k != len - 1 && $urandom_range(0, 79) == 0) begin
        send(beat(OP_CLEAR, pick_id(), DAT_W'($urandom), 1'($urandom), 1'($urandom),
                  CAP_W'($urandom)));
        break;
      end
    end
  endtask

  task automatic random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_burst(pick_id(), ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                         : $urandom_range(1, 6));
    end else if (pick < 80) begin
      send(read_beat());
    end else if (pick < 83) begin
      send(beat(OP_CLEAR, pick_id(), DAT_W'($urandom), 1'($urandom), 1'($urandom),
                CAP_W'($urandom)));
    end else if (pick < 90) begin
      send(beat(OP_NOP, ID_W'($urandom), DAT_W'($urandom), 1'($urandom), 1'($urandom),
                CAP_W'($urandom)));
    end else begin
      send(beat(OP_STORE, pick_id(), DAT_W'($urandom), 1'($urandom), 1'b1, CAP_W'($urandom)));
    end
  endtask

  initial begin
    int target;
    row_t r;
    beat_t b;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_tag[i] = '0;
      slot_len[i] = '0;
    end
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);

    //                   op        id     data   bv last cap       reps typed kind        ok  cnt
    script.push_back(step_row(OP_READ,  8'h00, 8'h00, 0, 0, 16'hFFFF, 1,  1, KIND_READ,  0, 0));
    script.push_back(step_row(OP_STORE, 8'hFF, 8'h00, 1, 0, 16'h0000, 1,  0, KIND_STORE, 0, 0));
    // later ids inside a burst do not retag the slot
    script.push_back(step_row(OP_STORE, 8'h00, 8'hFF, 1, 0, 16'hFFFF, 1,  0, KIND_STORE, 0, 0));
    script.push_back(step_row(OP_STORE, 8'h00, 8'hA5, 0, 0, 16'h0000, 1,  0, KIND_STORE, 0, 0));
    script.push_back(step_row(OP_STORE, 8'h00, 8'h5A, 1, 1, 16'hFFFF, 1,  1, KIND_STORE, 1, 3));
    script.push_back(step_row(OP_READ,  8'hFF, 8'hFF, 1, 1, 16'h0000, 1,  1, KIND_READ,  1, 0));
    script.push_back(step_row(OP_READ,  8'hFF, 8'h00, 0, 0, 16'hFFFF, 1,  0, KIND_READ,  0, 0));
    script.push_back(step_row(OP_READ,  8'hFF, 8'h00, 0, 0, 16'h0002, 1,  0, KIND_READ,  0, 0));
    script.push_back(step_row(OP_STORE, 8'h10, 8'h33, 0, 1, 16'h0000, 1,  1, KIND_STORE, 1, 0));
    script.push_back(step_row(OP_READ,  8'h10, 8'h00, 0, 0, 16'hFFFF, 1,  1, KIND_READ,  1, 0));
    script.push_back(step_row(OP_NOP,   8'hFF, 8'hFF, 1, 1, 16'hFFFF, 1,  0, KIND_STORE, 0, 0));
    script.push_back(step_row(OP_STORE, 8'hFF, 8'h11, 1, 0, 16'h0000, 1,  0, KIND_STORE, 0, 0));
    // read while the burst is open: committed length, fresh byte 0
    script.push_back(step_row(OP_READ,  8'hFF, 8'h00, 0, 0, 16'hFFFF, 1,  0, KIND_READ,  0, 0));
    script.push_back(step_row(OP_STORE, 8'hFF, 8'h22, 1, 1, 16'h0000, 1,  0, KIND_STORE, 0, 0));
    script.push_back(step_row(OP_CLEAR, 8'h00, 8'h00, 0, 0, 16'h0000, 1,  1, KIND_CLEAR, 1, 0));
    script.push_back(step_row(OP_READ,  8'hFF, 8'h00, 0, 0, 16'hFFFF, 1,  1, KIND_READ,  0, 0));
    script.push_back(step_row(OP_STORE, 8'h07, 8'h01, 1, 0, 16'h0000, 1,  0, KIND_STORE, 0, 0));
    // clear abandons the open burst
    script.push_back(step_row(OP_CLEAR, 8'hFF, 8'hFF, 1, 1, 16'hFFFF, 1,  1, KIND_CLEAR, 1, 0));
    script.push_back(step_row(OP_READ,  8'h07, 8'h00, 0, 0, 16'h0001, 1,  1, KIND_READ,  0, 0));
    // fill every slot with ids 0..31, then a new id finds the table full
    script.push_back(step_row(OP_STORE, 8'h00, 8'h80, 1, 1, 16'h0000, NUM_SLOTS,
                              1, KIND_STORE, 1, 1));
    script.push_back(step_row(OP_STORE, 8'hC8, 8'h00, 1, 1, 16'h0000, 1,  1, KIND_STORE, 0, 0));
    // reuse of slot 31 with more bytes than a slot holds
    script.push_back(step_row(OP_STORE, 8'h1F, 8'h00, 1, 0, 16'h0000, 70, 0, KIND_STORE, 0, 0));
    script.push_back(step_row(OP_STORE, 8'h1F, 8'hFF, 1, 1, 16'h0000, 1,  1, KIND_STORE, 1,
                              SLOT_BYTES_C));
    script.push_back(step_row(OP_READ,  8'h1F, 8'h00, 0, 0, 16'hFFFF, 1,  0, KIND_READ,  0, 0));
    script.push_back(step_row(OP_READ,  8'h1F, 8'h00, 0, 0, 16'd40,   1,  0, KIND_READ,  0, 0));
    script.push_back(step_row(OP_CLEAR, 8'h00, 8'h00, 0, 0, 16'h0000, 1,  1, KIND_CLEAR, 1, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    stall_pct = 20;
    gap_max = 3;
    foreach (script[i]) begin
      r = script[i];
      for (int k = 0; k < r.reps; k++) begin
        b = r.b;
        b.id = ID_W'(r.b.id + k);
        b.data = DAT_W'(r.b.data + k);
        offer(b, r.typed, r.want);
      end
    end
    drain();

    items_sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      stall_pct = stall_plan[ph];
      gap_max = gap_plan[ph];
      target = (ph + 1) * RANDOM_ITEMS / 6;
      if (ph == 2) begin
        // long receiver hold while reads keep coming: input side must back up
        holds_asked++;
        repeat (12) send(beat(OP_READ, id_pool[$urandom_range(0, ID_POOL - 1)],
                              DAT_W'($urandom), 1'($urandom), 1'($urandom), 16'hFFFF));
      end
      while (items_sent < target) random_op();
      if (ph == 3) drain();
    end
    drain();

    $display("Run covered %0d results checked, %0d dropped bursts on a full table,",
             results_checked, drops_seen);
    $display("%0d bytes truncated past slot size and %0d reads of absent ids.",
             bytes_cut, misses_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/krsc_pkg.sv
rtl/krsc_ctrl.sv
rtl/krsc_dp.sv
rtl/keyed_report_slot_cache.sv
tb/sv/tb.sv
